FILE: src/trajectory_start_alignment_core_assert.svh
// assertion macros for the trajectory start alignment core
`ifndef TRAJECTORY_START_ALIGNMENT_CORE_ASSERT_SVH
`define TRAJECTORY_START_ALIGNMENT_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define TSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsa: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define TSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsa: next-cycle check failed");
`else
`define TSA_ASSERT_IMP(lbl, ante, cons)
`define TSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/tsa_pkg.sv
package tsa_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YAW_MUL,
    ST_CORDIC,
    ST_YAW_FIN,
    ST_STEP_MUL,
    ST_SQRT,
    ST_ARC,
    ST_DIV,
    ST_BLEND_MUL,
    ST_SC_FIN,
    ST_OUT
  } tsa_state_t;

  // angles: 1/4096 rad for yaw, 1/65536 rad inside the cordic
  localparam int PI_Q12      = 12868;
  localparam int TWO_PI_Q12  = 25736;
  localparam int HALF_PI_Q16 = 102944;
  localparam int CORDIC_GAIN = 652032874;
  localparam int Q14_ONE     = 16384;

  // gimbal lock test factors (sarg is kept halved, so its factor is doubled)
  localparam int GIMBAL_NORM_K = 99999;
  localparam int GIMBAL_SARG_K = 200000;

  // operation counts of the shared units
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 17;

  // arctangent of 2^-i in 1/65536 rad
  function automatic logic signed [19:0] atan_q16(input logic [3:0] idx);
    logic signed [19:0] v;
    case (idx)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // clamp a rounded cordic output to Q1.14
  function automatic logic signed [15:0] clamp_q14(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'(Q14_ONE)) begin
      r = 16'(Q14_ONE);
    end else if (v < -36'(Q14_ONE)) begin
      r = -16'(Q14_ONE);
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

FILE: src/trajectory_start_alignment_core.sv
// Throughput: one item at a time; the next transfer is taken once the result
// is registered, or once an ego item's pose is stored. The time per item
// is set by the shared cordic (16 steps per angle), the bit-serial square
// root (32 steps) and the restoring divider (17 steps).
// Reset (rst_n, synchronous, active low) clears the pose state and the output valid flag.
`include "trajectory_start_alignment_core_assert.svh"
module trajectory_start_alignment_core
  import tsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  input  logic [127:0] in_tdata,
  // mode, first
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_qx, out_qy, out_qz, out_qw
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [19:0]  cfg_data
);

  tsa_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // captured item
  logic               mode_r, first_r;
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;

  // block state
  logic [19:0]        align_dist_r;
  logic signed [31:0] ego_px_r, ego_py_r, prev_px_r, prev_py_r;
  logic signed [15:0] ego_head_r, shift_head_r, yaw_r;
  logic signed [32:0] shift_x_r, shift_y_r;
  logic [31:0]        arc_r;
  logic               blend_r;

  // shared multiplier and yaw terms
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_full;
  logic signed [63:0] p_r;
  logic signed [33:0] norm_r, den_r;
  logic signed [32:0] num_r, sarg_r;
  logic signed [50:0] lim_r;
  logic               gimbal_r;

  // shared cordic
  logic signed [35:0] cx_r, cy_r;
  logic signed [19:0] cz_r;
  logic               catan_r;

  // square root, divider
  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [30:0] ax_r, ay_r;
  logic [20:0] dv_r;
  logic [16:0] q_r;

  // result and output register
  logic signed [31:0] res_x_r, res_y_r;
  logic signed [15:0] res_qx_r, res_qy_r, res_qz_r, res_qw_r;
  logic               out_valid_r;
  logic [127:0]       out_data_r;

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // weight in Q1.16
  logic [16:0] w_c;
  assign w_c = 17'(18'd65536 - {1'b0, q_r});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_YAW_MUL: begin
        case (cnt_r)
          5'd0: begin mul_a = 34'(qx_r); mul_b = 34'(qx_r); end
          5'd1: begin mul_a = 34'(qy_r); mul_b = 34'(qy_r); end
          5'd2: begin mul_a = 34'(qz_r); mul_b = 34'(qz_r); end
          5'd3: begin mul_a = 34'(qw_r); mul_b = 34'(qw_r); end
          5'd4: begin mul_a = 34'(qx_r); mul_b = 34'(qy_r); end
          5'd5: begin mul_a = 34'(qw_r); mul_b = 34'(qz_r); end
          5'd6: begin mul_a = 34'(qw_r); mul_b = 34'(qy_r); end
          5'd7: begin mul_a = 34'(qx_r); mul_b = 34'(qz_r); end
          5'd8: begin mul_a = norm_r; mul_b = 34'(GIMBAL_NORM_K); end
          5'd9: begin mul_a = 34'(sarg_r); mul_b = 34'(GIMBAL_SARG_K); end
          default: ;
        endcase
      end
      ST_STEP_MUL: begin
        case (cnt_r)
          5'd0: begin
            mul_a = 34'($signed({1'b0, ax_r}));
            mul_b = 34'($signed({1'b0, ax_r}));
          end
          5'd1: begin
            mul_a = 34'($signed({1'b0, ay_r}));
            mul_b = 34'($signed({1'b0, ay_r}));
          end
          default: ;
        endcase
      end
      ST_BLEND_MUL: begin
        mul_a = 34'($signed({1'b0, w_c}));
        case (cnt_r)
          5'd0:    mul_b = 34'(shift_x_r);
          5'd1:    mul_b = 34'(shift_y_r);
          5'd2:    mul_b = 34'(shift_head_r);
          default: mul_b = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // gimbal test and atan start vector
  logic [63:0]        sv_abs;
  logic signed [35:0] at_x0, at_y0;
  assign sv_abs = p_r[63] ? 64'(-p_r) : 64'(p_r);
  assign at_x0  = 36'(den_r);
  assign at_y0  = 36'(num_r) <<< 1;

  // one cordic step, vectoring or rotation
  logic signed [35:0] cdx, cdy;
  logic signed [19:0] ctab;
  logic               c_up;
  assign cdx  = cy_r >>> cnt_r[3:0];
  assign cdy  = cx_r >>> cnt_r[3:0];
  assign ctab = atan_q16(cnt_r[3:0]);
  assign c_up = catan_r ? !cy_r[35] : cz_r[19];

  // yaw from the vectoring angle
  logic signed [20:0] z_rnd;
  logic signed [15:0] yaw_c;
  assign z_rnd = (21'(cz_r) + 21'sd8) >>> 4;
  always_comb begin
    if (gimbal_r) begin
      yaw_c = '0;
    end else if (z_rnd > 21'(PI_Q12)) begin
      yaw_c = 16'(PI_Q12);
    end else if (z_rnd < -21'(PI_Q12)) begin
      yaw_c = -16'(PI_Q12);
    end else begin
      yaw_c = 16'(z_rnd);
    end
  end

  // heading correction, wrapped
  logic signed [16:0] hd_raw;
  logic signed [15:0] hd_wrap;
  assign hd_raw = 17'(yaw_c) - 17'(ego_head_r);
  always_comb begin
    if (hd_raw >= 17'(PI_Q12)) begin
      hd_wrap = 16'(hd_raw - 17'(TWO_PI_Q12));
    end else if (hd_raw < -17'(PI_Q12)) begin
      hd_wrap = 16'(hd_raw + 17'(TWO_PI_Q12));
    end else begin
      hd_wrap = 16'(hd_raw);
    end
  end

  // step from the previous point
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        ax_c, ay_c;
  logic               huge_c;
  assign dx_c   = 33'(px_r) - 33'(prev_px_r);
  assign dy_c   = 33'(py_r) - 33'(prev_py_r);
  assign ax_c   = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign ay_c   = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
  assign huge_c = ax_c[32] | ax_c[31] | ay_c[32] | ay_c[31];

  // square root step
  logic [63:0] sq_t;
  assign sq_t = sq_res_r + sq_bit_r;

  // arc length update
  logic [32:0] arc_sum;
  logic [31:0] arc_new;
  logic        blend_new;
  assign arc_sum   = {1'b0, arc_r} + {1'b0, sq_res_r[31:0]};
  assign arc_new   = arc_sum[32] ? 32'hFFFF_FFFF : arc_sum[31:0];
  assign blend_new = (arc_new <= {12'd0, align_dist_r}) && (align_dist_r != '0);

  // restoring divide step
  logic        div_ge;
  logic [20:0] dv_sub;
  assign div_ge = dv_r >= {1'b0, align_dist_r};
  assign dv_sub = dv_r - (div_ge ? {1'b0, align_dist_r} : 21'd0);

  // blend terms
  logic signed [63:0] rnd_c;
  logic signed [34:0] sum_c;
  logic signed [17:0] ysum;
  logic signed [15:0] yaw_b;
  logic signed [19:0] h_c;
  assign rnd_c = (p_r + 64'sd32768) >>> 16;
  assign sum_c = ((cnt_r == 5'd1) ? 35'(px_r) : 35'(py_r)) + $signed(rnd_c[34:0]);
  assign ysum  = 18'(yaw_r) + $signed(rnd_c[17:0]);
  always_comb begin
    if (ysum > 18'(TWO_PI_Q12)) begin
      yaw_b = 16'(TWO_PI_Q12);
    end else if (ysum < -18'(TWO_PI_Q12)) begin
      yaw_b = -16'(TWO_PI_Q12);
    end else begin
      yaw_b = 16'(ysum);
    end
  end
  assign h_c = 20'(yaw_b) <<< 3;

  // sine and cosine rounding
  logic signed [35:0] cos_rnd, sin_rnd;
  assign cos_rnd = (cx_r + 36'sd32768) >>> 16;
  assign sin_rnd = (cy_r + 36'sd32768) >>> 16;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 5'd1;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) state_nxt = ST_YAW_MUL;
      end
      ST_YAW_MUL: begin
        if (cnt_r == 5'd10) begin
          state_nxt = ST_CORDIC;
          cnt_nxt   = '0;
        end
      end
      ST_CORDIC: begin
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = catan_r ? ST_YAW_FIN : ST_SC_FIN;
          cnt_nxt   = '0;
        end
      end
      ST_YAW_FIN: begin
        cnt_nxt = '0;
        if (!mode_r) begin
          state_nxt = ST_IDLE;
        end else if (first_r) begin
          state_nxt = (align_dist_r != '0) ? ST_DIV : ST_OUT;
        end else if (blend_r) begin
          state_nxt = huge_c ? ST_ARC : ST_STEP_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_STEP_MUL: begin
        if (cnt_r == 5'd2) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end
      end
      ST_SQRT: begin
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          state_nxt = ST_ARC;
          cnt_nxt   = '0;
        end
      end
      ST_ARC: begin
        cnt_nxt   = '0;
        state_nxt = blend_new ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = ST_BLEND_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_BLEND_MUL: begin
        if (cnt_r == 5'd3) begin
          state_nxt = ST_CORDIC;
          cnt_nxt   = '0;
        end
      end
      ST_SC_FIN: begin
        state_nxt = ST_OUT;
        cnt_nxt   = '0;
      end
      ST_OUT: begin
        cnt_nxt = '0;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // configuration and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_dist_r <= '0;
      ego_px_r     <= '0;
      ego_py_r     <= '0;
      ego_head_r   <= '0;
      shift_x_r    <= '0;
      shift_y_r    <= '0;
      shift_head_r <= '0;
      prev_px_r    <= '0;
      prev_py_r    <= '0;
      arc_r        <= '0;
      blend_r      <= 1'b0;
    end else begin
      if (cfg_valid) align_dist_r <= cfg_data;
      if (state_r == ST_YAW_FIN) begin
        if (!mode_r) begin
          ego_px_r   <= px_r;
          ego_py_r   <= py_r;
          ego_head_r <= yaw_c;
        end else begin
          prev_px_r <= px_r;
          prev_py_r <= py_r;
          if (first_r) begin
            shift_head_r <= hd_wrap;
            shift_x_r    <= 33'(ego_px_r) - 33'(px_r);
            shift_y_r    <= 33'(ego_py_r) - 33'(py_r);
            arc_r        <= '0;
            blend_r      <= (align_dist_r != '0);
          end
        end
      end
      if (state_r == ST_ARC) begin
        arc_r   <= arc_new;
        blend_r <= blend_new;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= mul_full[63:0];
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_r  <= in_tuser[0];
          first_r <= in_tuser[1];
          px_r    <= in_tdata[31:0];
          py_r    <= in_tdata[63:32];
          qx_r    <= in_tdata[79:64];
          qy_r    <= in_tdata[95:80];
          qz_r    <= in_tdata[111:96];
          qw_r    <= in_tdata[127:112];
        end
      end
      ST_YAW_MUL: begin
        // products arrive in the cycle after their operands
        case (cnt_r)
          5'd1: begin
            norm_r <= 34'(p_r);
            den_r  <= 34'(p_r);
          end
          5'd2, 5'd3: begin
            norm_r <= norm_r + 34'(p_r);
            den_r  <= den_r - 34'(p_r);
          end
          5'd4: begin
            norm_r <= norm_r + 34'(p_r);
            den_r  <= den_r + 34'(p_r);
          end
          5'd5: num_r  <= 33'(p_r);
          5'd6: num_r  <= num_r + 33'(p_r);
          5'd7: sarg_r <= 33'(p_r);
          5'd8: sarg_r <= sarg_r - 33'(p_r);
          5'd9: lim_r  <= 51'(p_r);
          5'd10: begin
            gimbal_r <= (sv_abs >= 64'(lim_r)) || (num_r == '0 && den_r == '0);
            catan_r  <= 1'b1;
            // pre-rotate into the right half plane
            if (at_x0[35]) begin
              if (!at_y0[35]) begin
                cx_r <= at_y0;
                cy_r <= -at_x0;
                cz_r <= 20'(HALF_PI_Q16);
              end else begin
                cx_r <= -at_y0;
                cy_r <= at_x0;
                cz_r <= -20'(HALF_PI_Q16);
              end
            end else begin
              cx_r <= at_x0;
              cy_r <= at_y0;
              cz_r <= '0;
            end
          end
          default: ;
        endcase
      end
      ST_CORDIC: begin
        if (c_up) begin
          cx_r <= cx_r + cdx;
          cy_r <= cy_r - cdy;
          cz_r <= cz_r + ctab;
        end else begin
          cx_r <= cx_r - cdx;
          cy_r <= cy_r + cdy;
          cz_r <= cz_r - ctab;
        end
      end
      ST_YAW_FIN: begin
        yaw_r    <= yaw_c;
        res_x_r  <= px_r;
        res_y_r  <= py_r;
        res_qx_r <= qx_r;
        res_qy_r <= qy_r;
        res_qz_r <= qz_r;
        res_qw_r <= qw_r;
        dv_r     <= '0;
        ax_r     <= ax_c[30:0];
        ay_r     <= ay_c[30:0];
        if (huge_c) sq_res_r <= 64'h0000_0000_FFFF_FFFF;
      end
      ST_STEP_MUL: begin
        if (cnt_r == 5'd1) begin
          sq_n_r <= $unsigned(p_r);
        end else if (cnt_r == 5'd2) begin
          sq_n_r   <= sq_n_r + $unsigned(p_r);
          sq_res_r <= '0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
        end
      end
      ST_SQRT: begin
        if (sq_n_r >= sq_t) begin
          sq_n_r   <= sq_n_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_ARC: begin
        dv_r <= arc_new[20:0];
      end
      ST_DIV: begin
        q_r  <= {q_r[15:0], div_ge};
        dv_r <= {dv_sub[19:0], 1'b0};
      end
      ST_BLEND_MUL: begin
        case (cnt_r)
          5'd1: res_x_r <= sat32(sum_c);
          5'd2: res_y_r <= sat32(sum_c);
          5'd3: begin
            yaw_r   <= yaw_b;
            catan_r <= 1'b0;
            // quadrant fold of the half angle
            if (h_c > 20'(HALF_PI_Q16)) begin
              cx_r <= '0;
              cy_r <= 36'(CORDIC_GAIN);
              cz_r <= h_c - 20'(HALF_PI_Q16);
            end else if (h_c < -20'(HALF_PI_Q16)) begin
              cx_r <= '0;
              cy_r <= -36'(CORDIC_GAIN);
              cz_r <= h_c + 20'(HALF_PI_Q16);
            end else begin
              cx_r <= 36'(CORDIC_GAIN);
              cy_r <= '0;
              cz_r <= h_c;
            end
          end
          default: ;
        endcase
      end
      ST_SC_FIN: begin
        res_qx_r <= '0;
        res_qy_r <= '0;
        res_qz_r <= clamp_q14(sin_rnd);
        res_qw_r <= clamp_q14(cos_rnd);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= {res_qw_r, res_qz_r, res_qy_r, res_qx_r, res_y_r, res_x_r};
    end
  end

  // checks
  `TSA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `TSA_ASSERT_NEXT(a_out_from_seq, !out_tvalid && state_r != ST_OUT, !out_tvalid)
  `TSA_ASSERT_IMP(a_sqrt_bit_onehot, state_r == ST_SQRT, $onehot(sq_bit_r))

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import tsa_pkg::*;
();

  // aligned pose as carried on the result stream
  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pose_t;

  // one row of the directed stimulus
  typedef struct {
    int                 cfg;       // distance written before the row, -1 for none
    bit                 mode;
    bit                 first;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    bit                 thru;      // expected result is the input pose unchanged
  } row_t;

  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_CYCLES = 120;
  localparam int  STALL_LIMIT  = 3000;
  localparam int  N_ITEMS      = 1200;
  localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  logic [127:0] in_tdata = '0;
  // mode, first
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // out_x, out_y, out_qx, out_qy, out_qz, out_qw
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [19:0]  cfg_data = '0;

  // predictor state
  longint          dist_reg;
  longint          ego_x, ego_y, ego_yaw;
  longint          corr_x, corr_y, corr_yaw;
  longint          last_x, last_y;
  longint unsigned path_len;
  bit              align_on;

  pose_t pose_q[$];
  bit    failed = 1'b0;
  bit    long_hold = 1'b0;
  bit    no_idle = 1'b0;
  int    quiet_cycles = 0;
  row_t  rows[$];

  trajectory_start_alignment_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // vectoring cordic, result in 1/4096 rad
  function automatic longint cordic_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q16;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end
    end
    z = (z + 8) >>> 4;
    if (z > PI_Q12) z = PI_Q12;
    if (z < -PI_Q12) z = -PI_Q12;
    return z;
  endfunction

  // zyx yaw of a quaternion, zero near gimbal lock
  function automatic longint heading_of(longint qx, longint qy, longint qz, longint qw);
    longint norm, sarg;
    norm = qx * qx + qy * qy + qz * qz + qw * qw;
    sarg = -2 * (qx * qz - qw * qy);
    if (sarg * 100000 <= -99999 * norm || sarg * 100000 >= 99999 * norm) return 0;
    return cordic_atan2(2 * (qx * qy + qw * qz), qw * qw + qx * qx - qy * qy - qz * qz);
  endfunction

  // rotation cordic: sine and cosine of half the yaw in Q1.14
  function automatic void half_angle(input longint yaw, output longint s, output longint c);
    longint h, x, y, dx, dy;
    h = yaw * 8;
    x = CORDIC_GAIN;
    y = 0;
    if (h > HALF_PI_Q16) begin
      x = 0; y = CORDIC_GAIN; h -= HALF_PI_Q16;
    end else if (h < -HALF_PI_Q16) begin
      x = 0; y = -CORDIC_GAIN; h += HALF_PI_Q16;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (h >= 0) begin
        x -= dx; y += dy; h -= ATAN_Q16[i];
      end else begin
        x += dx; y -= dy; h += ATAN_Q16[i];
      end
    end
    c = (x + 32768) >>> 16;
    s = (y + 32768) >>> 16;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
  endfunction

  // floor of the 2d distance from the previous point
  function automatic longint unsigned step_len(longint x, longint y);
    longint unsigned ax, ay, n, res, b;
    ax = (x - last_x < 0) ? last_x - x : x - last_x;
    ay = (y - last_y < 0) ? last_y - y : y - last_y;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) return 64'hFFFF_FFFF;
    n = ax * ax + ay * ay;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // aligned pose of one accepted item; returns 0 for an ego item
  function automatic bit align_pose(input bit mode, input bit first, input pose_t p,
                                    output pose_t r);
    longint px, py, yaw, d, w, s, c;
    longint unsigned a;
    px = p.x;
    py = p.y;
    yaw = 0;
    r = p;
    if (!mode) begin
      ego_x = px;
      ego_y = py;
      ego_yaw = heading_of(p.qx, p.qy, p.qz, p.qw);
      return 0;
    end
    if (first) begin
      yaw = heading_of(p.qx, p.qy, p.qz, p.qw);
      d = yaw - ego_yaw;
      if (d >= PI_Q12) d -= TWO_PI_Q12;
      else if (d < -PI_Q12) d += TWO_PI_Q12;
      corr_yaw = d;
      corr_x = ego_x - px;
      corr_y = ego_y - py;
      path_len = 0;
      align_on = 1'b1;
    end else if (align_on) begin
      a = path_len + step_len(px, py);
      path_len = (a > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a;
      if (path_len > dist_reg) align_on = 1'b0;
      yaw = heading_of(p.qx, p.qy, p.qz, p.qw);
    end
    if (dist_reg == 0) align_on = 1'b0;
    last_x = px;
    last_y = py;
    if (align_on) begin
      w = 65536 - longint'((path_len << 16) / dist_reg);
      r.x = 32'(sat_pos(px + ((w * corr_x + 32768) >>> 16)));
      r.y = 32'(sat_pos(py + ((w * corr_y + 32768) >>> 16)));
      yaw = yaw + ((w * corr_yaw + 32768) >>> 16);
      if (yaw > TWO_PI_Q12) yaw = TWO_PI_Q12;
      if (yaw < -TWO_PI_Q12) yaw = -TWO_PI_Q12;
      half_angle(yaw, s, c);
      r.qx = '0;
      r.qy = '0;
      r.qz = 16'(s);
      r.qw = 16'(c);
    end
    return 1;
  endfunction

  // offer one item and record its expected result once transferred
  task automatic send_item(input bit mode, input bit first, input pose_t p, input bit thru);
    int    gap;
    pose_t r;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tuser  <= {first, mode};
    do @(posedge clk); while (!in_tready);
    if (align_pose(mode, first, p, r)) pose_q.insert(pose_q.size(), thru ? p : r);
  endtask

  // sender waits until every result is back and the block has gone quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dist(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= 20'(v);
    do @(posedge clk); while (!cfg_ready);
    dist_reg = v & 20'hFFFFF;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input int cfg, input bit mode, input bit first,
                         input int px, input int py,
                         input int qx, input int qy, input int qz, input int qw,
                         input bit thru);
    row_t rw;
    rw = '{cfg, mode, first, px, py, 16'(qx), 16'(qy), 16'(qz), 16'(qw), thru};
    rows.insert(rows.size(), rw);
  endtask

  function automatic pose_t rand_pose(input bit wild, input logic signed [31:0] px,
                                      input logic signed [31:0] py);
    pose_t p;
    p.x = px;
    p.y = py;
    if (wild) begin
      p.qx = 16'($urandom_range(0, 32768) - 16384);
      p.qy = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      p.qx = 16'($urandom_range(0, 800) - 400);
      p.qy = 16'($urandom_range(0, 800) - 400);
    end
    p.qz = 16'($urandom_range(0, 32768) - 16384);
    p.qw = 16'($urandom_range(0, 32768) - 16384);
    return p;
  endfunction

  // receiver with random back-pressure and one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (long_hold) begin
        gap = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare each result transfer with the oldest expected pose
  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pose_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
          failed = 1'b1;
        end
        if (got.y !== want.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
          failed = 1'b1;
        end
        if (got.qx !== want.qx) begin
          $display("%0t: out_qx expected %0d actual %0d", $time, want.qx, got.qx);
          failed = 1'b1;
        end
        if (got.qy !== want.qy) begin
          $display("%0t: out_qy expected %0d actual %0d", $time, want.qy, got.qy);
          failed = 1'b1;
        end
        if (got.qz !== want.qz) begin
          $display("%0t: out_qz expected %0d actual %0d", $time, want.qz, got.qz);
          failed = 1'b1;
        end
        if (got.qw !== want.qw) begin
          $display("%0t: out_qw expected %0d actual %0d", $time, want.qw, got.qw);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    pose_t p;
    int    sent, plen, step, cfgv;
    logic signed [31:0] bx, by;
    dist_reg = 0;
    ego_x = 0; ego_y = 0; ego_yaw = 0;
    corr_x = 0; corr_y = 0; corr_yaw = 0;
    last_x = 0; last_y = 0;
    path_len = 0;
    align_on = 1'b0;

    // point before any first point and the disabled distance pass through
    add_row(-1, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 16384, -16384, 16384, -16384, 1);
    add_row(-1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, -16384, 16384, -16384, 16384, 1);
    add_row(-1, 1, 0, 0, 0, 0, 0, 0, 0, 1);
    // ego item ignores first; full distance, mixed-attitude path
    add_row(1048575, 0, 1, 1000, -2000, 0, 0, 5792, 15812, 0);
    add_row(-1, 1, 1, 0, 0, 0, 0, -11585, 11585, 0);
    add_row(-1, 1, 0, 3000, 4000, 100, -100, -16384, 0, 0);
    add_row(-1, 1, 0, 6000, 8000, 11585, 0, 0, 11585, 0);   // pure roll, no yaw
    add_row(-1, 1, 0, 6000, 8000, 0, 0, 0, 0, 0);           // zero quaternion
    // huge step ends blending
    add_row(-1, 1, 0, 32'h8000_0000, 0, 0, 0, 0, 16384, 0);
    add_row(-1, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 16384, 1);
    // saturating positions and large yaw sum
    add_row(-1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16384, 0, 0);
    add_row(-1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, -16384, 1, 0);
    add_row(-1, 1, 0, 32'h7FFF_F000, 32'h8000_1000, 0, 0, 16384, 1, 0);
    add_row(-1, 1, 0, 32'h7FFF_F001, 32'h8000_1000, 0, 0, -16384, 1, 0);
    // shortest distance
    add_row(1, 0, 0, 0, 0, 0, 0, 0, 16384, 0);
    add_row(-1, 1, 1, 5, 5, 0, 0, 8000, 8000, 0);
    add_row(-1, 1, 0, 6, 5, 0, 0, 8000, 8000, 0);
    add_row(-1, 1, 0, 7, 5, 0, 0, 8000, 8000, 0);
    // distance cleared while a path blends
    add_row(5000, 1, 1, 100, 100, 0, 0, 3000, 16000, 0);
    add_row(0, 1, 0, 200, 100, 0, 0, 3000, 16000, 1);
    add_row(5000, 1, 0, 300, 100, 0, 0, 3000, 16000, 1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) write_dist(rows[i].cfg);
      p = '{rows[i].qw, rows[i].qz, rows[i].qy, rows[i].qx, rows[i].py, rows[i].px};
      send_item(rows[i].mode, rows[i].first, p, rows[i].thru);
    end

    // random phases: mostly ego, first point and short steps, some noise
    sent = 0;
    for (int ph = 0; sent < N_ITEMS; ph++) begin
      case (ph % 6)
        0:       cfgv = 0;
        1:       cfgv = 20'hFFFFF;
        2:       cfgv = 1;
        default: cfgv = $urandom_range(1, 20000);
      endcase
      write_dist(cfgv);
      no_idle = (ph % 5 == 4);
      if (ph == 3) long_hold = 1'b1;
      while (sent < (ph + 1) * 100 && sent < N_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          p = rand_pose(1'b1, $urandom, $urandom);
          send_item($urandom_range(0, 1), $urandom_range(0, 1), p, 1'b0);
          sent++;
        end else begin
          bx = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
          by = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
          p = rand_pose(1'b0, bx + $urandom_range(0, 40000) - 20000,
                        by + $urandom_range(0, 40000) - 20000);
          send_item(1'b0, $urandom_range(0, 1), p, 1'b0);
          p = rand_pose(1'b0, bx, by);
          send_item(1'b1, 1'b1, p, 1'b0);
          sent += 2;
          plen = $urandom_range(2, 12);
          step = (cfgv > 16) ? cfgv / 6 : 4;
          for (int k = 0; k < plen; k++) begin
            bx = bx + $urandom_range(0, step);
            by = by + $urandom_range(0, step) - step / 2;
            p = rand_pose(1'b0, bx, by);
            send_item(1'b1, 1'b0, p, 1'b0);
            sent++;
          end
        end
        if (sent > (ph * 100 + 50) && ph == 2) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pose_q.size() != 0);
        end
      end
    end

    drain();
    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
